// File: hdl/sfr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sfr_pkg: shared types and constants of the serial frame receiver
// Sync bytes, event codes, the result struct and configuration port sizes.
// ----------------------------------------------------------------------------
package sfr_pkg;

  // frame sync bytes
  localparam logic [7:0] SYNC_DOLLAR = 8'h24;
  localparam logic [7:0] SYNC_M      = 8'h4D;
  localparam logic [7:0] SYNC_ARROW  = 8'h3E;

  // configuration port sizes and register map
  localparam int unsigned PADDR_W = 2;
  localparam int unsigned PDATA_W = 32;
  localparam logic [PADDR_W-1:0] REG_DEV_ID = 2'd0;

  // result event codes
  typedef enum logic [1:0] {
    EVT_PAYLOAD = 2'd0,
    EVT_GOOD    = 2'd1,
    EVT_BAD     = 2'd2
  } event_kind_e;

  // one result beat
  typedef struct packed {
    event_kind_e event_kind;
    logic [7:0]  payload_byte;
    logic [5:0]  payload_index;
    logic [7:0]  frame_command;
    logic [6:0]  frame_length;
  } evt_t;

endpackage
`default_nettype wire

// File: hdl/sfr_byte_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sfr_byte_if: received byte channel
// Valid/ready channel carrying one byte from the serial link per beat.
// ----------------------------------------------------------------------------
interface sfr_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface
`default_nettype wire

// File: hdl/sfr_evt_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sfr_evt_if: frame event channel
// Valid/ready channel carrying payload bytes and end-of-frame reports.
// ----------------------------------------------------------------------------
interface sfr_evt_if;
  logic                valid;
  logic                ready;
  sfr_pkg::event_kind_e event_kind;
  logic [7:0]          payload_byte;
  logic [5:0]          payload_index;
  logic [7:0]          frame_command;
  logic [6:0]          frame_length;

  modport source (output valid, output event_kind, output payload_byte,
                  output payload_index, output frame_command, output frame_length,
                  input ready);
  modport sink   (input valid, input event_kind, input payload_byte,
                  input payload_index, input frame_command, input frame_length,
                  output ready);
endinterface
`default_nettype wire

// File: hdl/sfr_cfg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sfr_cfg: configuration registers
// APB-style register port holding the expected device id.
// ----------------------------------------------------------------------------
module sfr_cfg (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [sfr_pkg::PADDR_W-1:0] paddr,
  input  wire logic [sfr_pkg::PDATA_W-1:0] pwdata,
  output logic      [sfr_pkg::PDATA_W-1:0] prdata,
  output logic                             pready,
  output logic      [7:0]                  dev_id_o
);

  logic [7:0] dev_id_q;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready
                  && (paddr == sfr_pkg::REG_DEV_ID);

  // device id register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_id_q <= 8'd0;
    end else if (wr_en) begin
      dev_id_q <= pwdata[7:0];
    end
  end

  // read back
  always_comb begin
    prdata = '0;
    if (paddr == sfr_pkg::REG_DEV_ID) begin
      prdata = sfr_pkg::PDATA_W'(dev_id_q);
    end
  end

  assign dev_id_o = dev_id_q;

endmodule
`default_nettype wire

// File: hdl/sfr_in_stage.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sfr_in_stage: input register
// Captures one received byte per beat and holds it until the parser takes it.
// ----------------------------------------------------------------------------
module sfr_in_stage (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  input  wire logic [7:0] in_byte_i,
  output logic            in_ready_o,
  input  wire logic       take_i,
  output logic            valid_o,
  output logic      [7:0] byte_o
);

  logic       valid_q;
  logic [7:0] byte_q;
  logic       load;

  assign in_ready_o = !valid_q || take_i;
  assign load       = in_valid_i && in_ready_o;

  // valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  // byte holding register
  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= in_byte_i;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;

endmodule
`default_nettype wire

// File: hdl/sfr_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sfr_parser: frame parser
// Header hunt, length and id checks, command capture, payload indexing and XOR checksum.
// ----------------------------------------------------------------------------
module sfr_parser #(
  parameter int unsigned MAX_PAYLOAD = 64
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          take_i,
  input  wire logic [7:0]    byte_i,
  input  wire logic [7:0]    dev_id_i,
  output logic               evt_valid_o,
  output sfr_pkg::evt_t      evt_o
);

  localparam int unsigned LEN_W   = $clog2(MAX_PAYLOAD + 1);
  localparam logic [7:0]  MAX_LEN = 8'(MAX_PAYLOAD);

  // parser phase codes
  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_DOLLAR = 3'd1;
  localparam logic [2:0] PH_M      = 3'd2;
  localparam logic [2:0] PH_ARROW  = 3'd3;
  localparam logic [2:0] PH_LEN    = 3'd4;
  localparam logic [2:0] PH_CMD    = 3'd5;
  localparam logic [2:0] PH_BODY   = 3'd6;

  logic [2:0]       phase_q, phase_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic [LEN_W-1:0] cnt_q, cnt_d;
  logic [7:0]       xor_q, xor_d;
  logic [7:0]       cmd_q, cmd_d;
  logic [7:0]       len_ext;
  logic [7:0]       cnt_ext;
  logic             evt_v;

  assign len_ext = 8'(len_q);
  assign cnt_ext = 8'(cnt_q);

  // next state and event for the byte at hand
  always_comb begin
    phase_d = phase_q;
    len_d   = len_q;
    cnt_d   = cnt_q;
    xor_d   = xor_q;
    cmd_d   = cmd_q;
    evt_v   = 1'b0;
    evt_o.event_kind    = sfr_pkg::EVT_PAYLOAD;
    evt_o.payload_byte  = 8'd0;
    evt_o.payload_index = 6'd0;
    evt_o.frame_command = cmd_q;
    evt_o.frame_length  = len_ext[6:0];
    case (phase_q)
      PH_DOLLAR: begin
        phase_d = (byte_i == sfr_pkg::SYNC_M) ? PH_M : PH_IDLE;
      end
      PH_M: begin
        phase_d = (byte_i == sfr_pkg::SYNC_ARROW) ? PH_ARROW : PH_IDLE;
      end
      PH_ARROW: begin
        if (byte_i > MAX_LEN) begin
          phase_d = PH_IDLE;
        end else begin
          len_d   = LEN_W'(byte_i);
          cnt_d   = '0;
          xor_d   = byte_i;
          phase_d = PH_LEN;
        end
      end
      PH_LEN: begin
        cmd_d   = byte_i;
        xor_d   = xor_q ^ byte_i;
        phase_d = PH_CMD;
      end
      PH_CMD: begin
        if (byte_i == dev_id_i) begin
          xor_d   = xor_q ^ byte_i;
          phase_d = PH_BODY;
        end else begin
          cmd_d   = 8'd0;
          phase_d = PH_IDLE;
        end
      end
      PH_BODY: begin
        evt_v = 1'b1;
        if (cnt_q < len_q) begin
          // payload byte
          xor_d = xor_q ^ byte_i;
          cnt_d = cnt_q + LEN_W'(1);
          evt_o.payload_byte  = byte_i;
          evt_o.payload_index = cnt_ext[5:0];
        end else begin
          // checksum byte closes the frame
          phase_d = PH_IDLE;
          evt_o.event_kind = (xor_q == byte_i) ? sfr_pkg::EVT_GOOD : sfr_pkg::EVT_BAD;
        end
      end
      default: begin
        // idle, and the unused code behaves the same
        phase_d = (byte_i == sfr_pkg::SYNC_DOLLAR) ? PH_DOLLAR : PH_IDLE;
      end
    endcase
  end

  // parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      len_q   <= '0;
      cnt_q   <= '0;
      xor_q   <= 8'd0;
      cmd_q   <= 8'd0;
    end else if (take_i) begin
      phase_q <= phase_d;
      len_q   <= len_d;
      cnt_q   <= cnt_d;
      xor_q   <= xor_d;
      cmd_q   <= cmd_d;
    end
  end

  assign evt_valid_o = take_i && evt_v;

endmodule
`default_nettype wire

// File: hdl/sfr_out_stage.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sfr_out_stage: result register
// Holds one event beat for the sink and frees itself as the beat is taken.
// ----------------------------------------------------------------------------
module sfr_out_stage (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          evt_valid_i,
  input  wire sfr_pkg::evt_t evt_i,
  output logic               can_load_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output sfr_pkg::evt_t      out_evt_o
);

  logic          valid_q;
  sfr_pkg::evt_t evt_q;

  assign can_load_o = !valid_q || out_ready_i;

  // valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (can_load_o) begin
      valid_q <= evt_valid_i;
    end
  end

  // event payload
  always_ff @(posedge clk_i) begin
    if (can_load_o && evt_valid_i) begin
      evt_q <= evt_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_evt_o   = evt_q;

endmodule
`default_nettype wire

// File: hdl/serial_frame_receiver.sv
`default_nettype none
// ----------------------------------------------------------------------------
// serial_frame_receiver: framing receiver for a MultiWii-style serial link
// Hunts for '$' 'M' '>' frames, checks length limit and device id, emits
// every payload byte with its index and a good/bad report on the checksum.
// ----------------------------------------------------------------------------
// Usage
//   rx_i  : one received byte per beat (valid/ready sink)
//   evt_o : zero or one event per byte (valid/ready source): a payload byte
//           with its index, or an end-of-frame report with command and length
//   APB   : register 0 at address 0 holds the expected device id
// Path: a byte is held in the input register and its event is shown from
//   the result register, with the parser logic between the two.
// Throughput: one byte per cycle while the result register can load; the
//   parser state update is one pass of logic from input to result register.
// Reset: the parser goes back to hunting for '$', the device id reads zero
//   and both registers are empty.
// Stall: while evt_o is held off the result register keeps its beat, the
//   input register fills, and rx_i.ready drops only when both are occupied.
// Bytes that raise no event also wait in the input register while the
//   result register holds a beat that the sink has not taken.
// ----------------------------------------------------------------------------
module serial_frame_receiver #(
  parameter int unsigned MAX_PAYLOAD = 64
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  sfr_byte_if.sink                         rx_i,
  sfr_evt_if.source                        evt_o,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [sfr_pkg::PADDR_W-1:0] paddr,
  input  wire logic [sfr_pkg::PDATA_W-1:0] pwdata,
  output logic      [sfr_pkg::PDATA_W-1:0] prdata,
  output logic                             pready
);

  logic          [7:0] dev_id;
  logic                stage_valid;
  logic          [7:0] stage_byte;
  logic                can_load;
  logic                take;
  logic                evt_valid;
  sfr_pkg::evt_t       evt;
  sfr_pkg::evt_t       out_evt;

  // configuration registers
  sfr_cfg u_cfg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .dev_id_o (dev_id)
  );

  // input register
  sfr_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (rx_i.valid),
    .in_byte_i  (rx_i.rx_byte),
    .in_ready_o (rx_i.ready),
    .take_i     (take),
    .valid_o    (stage_valid),
    .byte_o     (stage_byte)
  );

  assign take = stage_valid && can_load;

  // frame parser
  sfr_parser #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (take),
    .byte_i      (stage_byte),
    .dev_id_i    (dev_id),
    .evt_valid_o (evt_valid),
    .evt_o       (evt)
  );

  // result register
  sfr_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .evt_valid_i (evt_valid),
    .evt_i       (evt),
    .can_load_o  (can_load),
    .out_valid_o (evt_o.valid),
    .out_ready_i (evt_o.ready),
    .out_evt_o   (out_evt)
  );

  assign evt_o.event_kind    = out_evt.event_kind;
  assign evt_o.payload_byte  = out_evt.payload_byte;
  assign evt_o.payload_index = out_evt.payload_index;
  assign evt_o.frame_command = out_evt.frame_command;
  assign evt_o.frame_length  = out_evt.frame_length;

endmodule
`default_nettype wire
